@@ sv/gptm_pkg.sv @@
// shared types, constants and command/status structs for the gamepad input block
package gptm_pkg;

   // width of the shared remainder unit and its step count
   localparam int DivW = 9;
   localparam logic [3:0] DivSteps = 4'(DivW);

   // button word bit positions, active low
   localparam int BitSelect = 0;
   localparam int BitStart  = 3;
   localparam int BitUp     = 4;
   localparam int BitRight  = 5;
   localparam int BitDown   = 6;
   localparam int BitLeft   = 7;
   localparam int BitMenu   = 10;
   localparam int BitPower  = 11;
   localparam int BitTurboA = 12;
   localparam int BitFireA  = 13;
   localparam int BitFireB  = 14;
   localparam int BitTurboB = 15;

   localparam logic [15:0] WordIdle = 16'hFFFF;

   // touch windows
   localparam logic [9:0] SelectLo = 10'd320;
   localparam logic [9:0] SelectHi = 10'd480;
   localparam logic [9:0] StartHi  = 10'd80;

   // register reset values
   localparam logic [10:0] StickThresholdRst = 11'd500;
   localparam logic [4:0]  TurboRateCountRst = 5'd6;
   localparam logic [7:0]  TurboPhaseWrapRst = 8'd210;
   localparam logic [5:0]  MenuToggleHoldRst = 6'd20;
   localparam logic [5:0]  MenuRepeatHoldRst = 6'd15;

   // state reset values
   localparam logic [2:0] VolumeRst     = 3'd4;
   localparam logic [2:0] BrightnessRst = 3'd2;
   localparam logic [3:0] TurboRateRst  = 4'd3;
   localparam logic [2:0] LevelMax      = 3'd4;
   localparam logic [4:0] RateCountMax  = 5'd16;

   typedef enum logic [2:0] {
      REG_STICK_THRESHOLD  = 3'd0,
      REG_TURBO_RATE_COUNT = 3'd1,
      REG_TURBO_PHASE_WRAP = 3'd2,
      REG_MENU_TOGGLE_HOLD = 3'd3,
      REG_MENU_REPEAT_HOLD = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_RATE_A,
      OP_RATE_B,
      OP_PHASE_A_MOD,
      OP_PHASE_A_WRAP,
      OP_PHASE_B_MOD,
      OP_PHASE_B_WRAP
   } div_op_type;

   typedef struct packed {
      logic [10:0] stick_threshold;
      logic [4:0]  turbo_rate_count;
      logic [7:0]  turbo_phase_wrap;
      logic [5:0]  menu_toggle_hold;
      logic [5:0]  menu_repeat_hold;
   } cfg_type;

   typedef struct packed {
      logic [11:0] stick_x;
      logic [11:0] stick_y;
      logic        fire_a;
      logic        fire_b;
      logic        touched;
      logic [9:0]  touch_x;
      logic        turbo_a_held;
      logic        turbo_b_held;
      logic        menu_held;
      logic        power_held;
   } req_item_type;

   typedef struct packed {
      logic [15:0] button_word;
      logic        menu_shown;
      logic [2:0]  volume_out;
      logic [2:0]  brightness_out;
      logic        vertical_stretch;
      logic        horizontal_stretch;
      logic [3:0]  turbo_a_rate_out;
      logic [3:0]  turbo_b_rate_out;
   } rsp_item_type;

   typedef struct packed {
      logic       capture;
      logic       front;
      logic       menu;
      logic       start;
      div_op_type start_op;
      logic       commit;
      div_op_type commit_op;
      logic       clear_a;
      logic       clear_b;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic menu_open;
      logic hold_zero;
      logic turbo_a_pressed;
      logic turbo_b_pressed;
      logic chan_a_active;
      logic chan_b_active;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

@@ sv/gptm_rem.sv @@
// iterative remainder unit, one quotient bit per cycle
module gptm_rem
   import gptm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DivW-1:0] dividend,
   input  logic [DivW-1:0] divisor,
   output logic            busy,
   output logic [DivW-1:0] remainder
);

   logic [DivW-1:0] dvd_ff, dvd_in;
   logic [DivW-1:0] dvs_ff, dvs_in;
   logic [DivW-1:0] rem_ff, rem_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [DivW:0]   trial;
   logic [DivW:0]   diff;

   assign trial = {rem_ff, dvd_ff[DivW-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = DivSteps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DivW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DivW-1:0];
         end else begin
            rem_in = trial[DivW-1:0];
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/gptm_datapath.sv @@
// poll state, button word decode, menu updates, autofire and the result register
module gptm_datapath
   import gptm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_item_type req_item,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output rsp_item_type rsp_item
);

   req_item_type item_ff, item_in;
   logic [15:0]  word_ff, word_in;
   logic [5:0]   hold_ff, hold_in;
   logic         menu_ff, menu_in;
   logic [2:0]   vol_ff, vol_in;
   logic [2:0]   bri_ff, bri_in;
   logic         sv_ff, sv_in;
   logic         sh_ff, sh_in;
   logic [3:0]   rate_a_ff, rate_a_in;
   logic [3:0]   rate_b_ff, rate_b_in;
   logic [7:0]   phase_a_ff, phase_a_in;
   logic [7:0]   phase_b_ff, phase_b_in;
   rsp_item_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;

   logic signed [12:0] sx_ext, sy_ext, thr_pos, thr_neg;
   logic [15:0]        word_front;
   logic [5:0]         hold_dec;
   logic               in_select_window;
   logic [2:0]         vol_up, bri_up;

   logic            div_start;
   logic [DivW-1:0] div_dividend, div_divisor, div_rem;
   logic            div_busy;
   logic [4:0]      rate_count;
   logic [DivW-1:0] phase_wrap;

   // poll decode
   always_comb begin
      sx_ext  = signed'({item_ff.stick_x[11], item_ff.stick_x});
      sy_ext  = signed'({item_ff.stick_y[11], item_ff.stick_y});
      thr_pos = signed'({2'b00, cfg.stick_threshold});
      thr_neg = -thr_pos;
      hold_dec = (hold_ff != 6'd0) ? hold_ff - 6'd1 : 6'd0;
      in_select_window = (item_ff.touch_x > SelectLo) && (item_ff.touch_x < SelectHi);

      word_front = WordIdle;
      word_front[BitRight]  = !(sx_ext > thr_pos);
      word_front[BitLeft]   = !(sx_ext < thr_neg);
      word_front[BitUp]     = !(sy_ext < thr_neg);
      word_front[BitDown]   = !(sy_ext > thr_pos);
      word_front[BitFireA]  = !item_ff.fire_a;
      word_front[BitFireB]  = !item_ff.fire_b;
      word_front[BitSelect] = !(item_ff.touched && in_select_window);
      word_front[BitStart]  = !(item_ff.touched && !in_select_window &&
                                (item_ff.touch_x != 10'd0) && (item_ff.touch_x < StartHi));
      word_front[BitTurboA] = !item_ff.turbo_a_held;
      word_front[BitTurboB] = !item_ff.turbo_b_held;
      word_front[BitMenu]   = !item_ff.menu_held;
      word_front[BitPower]  = !item_ff.power_held;
   end

   // divider operand selection
   always_comb begin
      if (cfg.turbo_rate_count == 5'd0) begin
         rate_count = 5'd1;
      end else if (cfg.turbo_rate_count > RateCountMax) begin
         rate_count = RateCountMax;
      end else begin
         rate_count = cfg.turbo_rate_count;
      end
      phase_wrap = (cfg.turbo_phase_wrap == 8'd0) ? 9'd256 : {1'b0, cfg.turbo_phase_wrap};

      div_start = cmd.start;
      unique case (cmd.start_op)
         OP_RATE_A: begin
            div_dividend = {4'd0, {1'b0, rate_a_ff} + 5'd1};
            div_divisor  = {4'd0, rate_count};
         end
         OP_RATE_B: begin
            div_dividend = {4'd0, {1'b0, rate_b_ff} + 5'd1};
            div_divisor  = {4'd0, rate_count};
         end
         OP_PHASE_A_MOD: begin
            div_dividend = {1'b0, phase_a_ff};
            div_divisor  = {4'd0, rate_a_ff, 1'b0};
         end
         OP_PHASE_A_WRAP: begin
            div_dividend = {1'b0, phase_a_ff} + 9'd1;
            div_divisor  = phase_wrap;
         end
         OP_PHASE_B_MOD: begin
            div_dividend = {1'b0, phase_b_ff};
            div_divisor  = {4'd0, rate_b_ff, 1'b0};
         end
         OP_PHASE_B_WRAP: begin
            div_dividend = {1'b0, phase_b_ff} + 9'd1;
            div_divisor  = phase_wrap;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = 9'd1;
         end
      endcase
   end

   gptm_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   // state updates under command
   always_comb begin
      item_in    = item_ff;
      word_in    = word_ff;
      hold_in    = hold_ff;
      menu_in    = menu_ff;
      vol_in     = vol_ff;
      bri_in     = bri_ff;
      sv_in      = sv_ff;
      sh_in      = sh_ff;
      rate_a_in  = rate_a_ff;
      rate_b_in  = rate_b_ff;
      phase_a_in = phase_a_ff;
      phase_b_in = phase_b_ff;
      vol_up     = vol_ff;
      bri_up     = bri_ff;

      if (cmd.capture) begin
         item_in = req_item;
      end

      if (cmd.front) begin
         word_in = word_front;
         hold_in = hold_dec;
         if (!word_front[BitMenu] && (hold_dec == 6'd0)) begin
            menu_in = !menu_ff;
            hold_in = cfg.menu_toggle_hold;
         end
      end

      if (cmd.menu) begin
         if (!word_ff[BitUp] && (vol_ff < LevelMax)) begin
            vol_up = vol_ff + 3'd1;
         end
         vol_in = vol_up;
         if (!word_ff[BitDown] && (vol_up != 3'd0)) begin
            vol_in = vol_up - 3'd1;
         end
         if (!word_ff[BitRight] && (bri_ff < LevelMax)) begin
            bri_up = bri_ff + 3'd1;
         end
         bri_in = bri_up;
         if (!word_ff[BitLeft] && (bri_up != 3'd0)) begin
            bri_in = bri_up - 3'd1;
         end
         sv_in = sv_ff ^ !word_ff[BitFireA];
         sh_in = sh_ff ^ !word_ff[BitFireB];
         if (word_ff != WordIdle) begin
            hold_in = cfg.menu_repeat_hold;
         end
      end

      if (cmd.commit) begin
         unique case (cmd.commit_op)
            OP_RATE_A:       rate_a_in = div_rem[3:0];
            OP_RATE_B:       rate_b_in = div_rem[3:0];
            // autofire: fire pressed only on the phase that divides evenly
            OP_PHASE_A_MOD:  word_in[BitFireA] = (div_rem != '0);
            OP_PHASE_A_WRAP: phase_a_in = div_rem[7:0];
            OP_PHASE_B_MOD:  word_in[BitFireB] = (div_rem != '0);
            OP_PHASE_B_WRAP: phase_b_in = div_rem[7:0];
            default:         word_in = word_ff;
         endcase
      end

      if (cmd.clear_a) begin
         phase_a_in = 8'd0;
      end
      if (cmd.clear_b) begin
         phase_b_in = 8'd0;
      end
   end

   // result register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_in.button_word        = word_ff;
         out_in.menu_shown         = menu_ff;
         out_in.volume_out         = vol_ff;
         out_in.brightness_out     = bri_ff;
         out_in.vertical_stretch   = sv_ff;
         out_in.horizontal_stretch = sh_ff;
         out_in.turbo_a_rate_out   = rate_a_ff;
         out_in.turbo_b_rate_out   = rate_b_ff;
         out_valid_in              = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      word_ff <= word_in;
      out_ff  <= out_in;
      if (reset) begin
         hold_ff      <= 6'd0;
         menu_ff      <= 1'b0;
         vol_ff       <= VolumeRst;
         bri_ff       <= BrightnessRst;
         sv_ff        <= 1'b0;
         sh_ff        <= 1'b0;
         rate_a_ff    <= TurboRateRst;
         rate_b_ff    <= TurboRateRst;
         phase_a_ff   <= 8'd0;
         phase_b_ff   <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         menu_ff      <= menu_in;
         vol_ff       <= vol_in;
         bri_ff       <= bri_in;
         sv_ff        <= sv_in;
         sh_ff        <= sh_in;
         rate_a_ff    <= rate_a_in;
         rate_b_ff    <= rate_b_in;
         phase_a_ff   <= phase_a_in;
         phase_b_ff   <= phase_b_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      status.menu_open       = menu_ff;
      status.hold_zero       = (hold_ff == 6'd0);
      status.turbo_a_pressed = !word_ff[BitTurboA];
      status.turbo_b_pressed = !word_ff[BitTurboB];
      status.chan_a_active   = (rate_a_ff != 4'd0) && !word_ff[BitTurboA];
      status.chan_b_active   = (rate_b_ff != 4'd0) && !word_ff[BitTurboB];
      status.div_busy        = div_busy;
      status.out_free        = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_item   = out_ff;

endmodule

@@ sv/gptm_ctrl.sv @@
// poll sequencer: decode, menu or autofire branch, remainder jobs, result load
module gptm_ctrl
   import gptm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FRONT,
      S_BRANCH,
      S_MENU,
      S_CHAN_A,
      S_CHAN_B,
      S_DIV,
      S_OUT
   } state_type;

   state_type  state_ff, state_in;
   div_op_type op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.start_op  = op_ff;
      cmd.commit_op = op_ff;
      req_tready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_FRONT;
            end
         end
         S_FRONT: begin
            cmd.front = 1'b1;
            state_in  = S_BRANCH;
         end
         S_BRANCH: begin
            if (status.menu_open) begin
               state_in = status.hold_zero ? S_MENU : S_OUT;
            end else begin
               state_in = S_CHAN_A;
            end
         end
         S_MENU: begin
            cmd.menu = 1'b1;
            if (status.turbo_a_pressed) begin
               cmd.start    = 1'b1;
               cmd.start_op = OP_RATE_A;
               op_in        = OP_RATE_A;
               state_in     = S_DIV;
            end else if (status.turbo_b_pressed) begin
               cmd.start    = 1'b1;
               cmd.start_op = OP_RATE_B;
               op_in        = OP_RATE_B;
               state_in     = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_CHAN_A: begin
            if (status.chan_a_active) begin
               cmd.start    = 1'b1;
               cmd.start_op = OP_PHASE_A_MOD;
               op_in        = OP_PHASE_A_MOD;
               state_in     = S_DIV;
            end else begin
               cmd.clear_a = 1'b1;
               state_in    = S_CHAN_B;
            end
         end
         S_CHAN_B: begin
            if (status.chan_b_active) begin
               cmd.start    = 1'b1;
               cmd.start_op = OP_PHASE_B_MOD;
               op_in        = OP_PHASE_B_MOD;
               state_in     = S_DIV;
            end else begin
               cmd.clear_b = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_DIV: begin
            if (!status.div_busy) begin
               cmd.commit = 1'b1;
               // next job never depends on the one being committed
               unique case (op_ff)
                  OP_RATE_A: begin
                     if (status.turbo_b_pressed) begin
                        cmd.start    = 1'b1;
                        cmd.start_op = OP_RATE_B;
                        op_in        = OP_RATE_B;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  OP_RATE_B: begin
                     state_in = S_OUT;
                  end
                  OP_PHASE_A_MOD: begin
                     cmd.start    = 1'b1;
                     cmd.start_op = OP_PHASE_A_WRAP;
                     op_in        = OP_PHASE_A_WRAP;
                  end
                  OP_PHASE_A_WRAP: begin
                     state_in = S_CHAN_B;
                  end
                  OP_PHASE_B_MOD: begin
                     cmd.start    = 1'b1;
                     cmd.start_op = OP_PHASE_B_WRAP;
                     op_in        = OP_PHASE_B_WRAP;
                  end
                  OP_PHASE_B_WRAP: begin
                     state_in = S_OUT;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_RATE_A;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

@@ sv/gamepad_turbo_menu_input_top.sv @@
// a poll runs through decode, then, unless the open menu is held off, the menu branch or
// autofire; each remainder job (rate step, phase test, phase wrap) runs in the 9-step
// shared unit, up to two per menu poll and four per autofire poll; one poll in flight,
// and the next beat is taken while the previous result waits in the output register for
// rsp_tready
// reset: synchronous, active high; restores register defaults, menu and turbo state.
module gamepad_turbo_menu_input_top
   import gptm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // stick_x[11:0], stick_y[23:12], fire_a[24], fire_b[25], touched[26],
   // touch_x[36:27], turbo_a_held[37], turbo_b_held[38], menu_held[39], power_held[40]
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // button_word[15:0], menu_shown[16], volume_out[19:17], brightness_out[22:20],
   // vertical_stretch[23], horizontal_stretch[24], turbo_a_rate_out[28:25],
   // turbo_b_rate_out[32:29]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   cmd_type       cmd;
   status_type    status;

   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            REG_STICK_THRESHOLD:  cfg_in.stick_threshold  = csr_pwdata[10:0];
            REG_TURBO_RATE_COUNT: cfg_in.turbo_rate_count = csr_pwdata[4:0];
            REG_TURBO_PHASE_WRAP: cfg_in.turbo_phase_wrap = csr_pwdata[7:0];
            REG_MENU_TOGGLE_HOLD: cfg_in.menu_toggle_hold = csr_pwdata[5:0];
            REG_MENU_REPEAT_HOLD: cfg_in.menu_repeat_hold = csr_pwdata[5:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_STICK_THRESHOLD:  csr_prdata = {21'd0, cfg_ff.stick_threshold};
         REG_TURBO_RATE_COUNT: csr_prdata = {27'd0, cfg_ff.turbo_rate_count};
         REG_TURBO_PHASE_WRAP: csr_prdata = {24'd0, cfg_ff.turbo_phase_wrap};
         REG_MENU_TOGGLE_HOLD: csr_prdata = {26'd0, cfg_ff.menu_toggle_hold};
         REG_MENU_REPEAT_HOLD: csr_prdata = {26'd0, cfg_ff.menu_repeat_hold};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_threshold  <= StickThresholdRst;
         cfg_ff.turbo_rate_count <= TurboRateCountRst;
         cfg_ff.turbo_phase_wrap <= TurboPhaseWrapRst;
         cfg_ff.menu_toggle_hold <= MenuToggleHoldRst;
         cfg_ff.menu_repeat_hold <= MenuRepeatHoldRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_item.stick_x      = req_tdata[11:0];
      req_item.stick_y      = req_tdata[23:12];
      req_item.fire_a       = req_tdata[24];
      req_item.fire_b       = req_tdata[25];
      req_item.touched      = req_tdata[26];
      req_item.touch_x      = req_tdata[36:27];
      req_item.turbo_a_held = req_tdata[37];
      req_item.turbo_b_held = req_tdata[38];
      req_item.menu_held    = req_tdata[39];
      req_item.power_held   = req_tdata[40];
   end

   assign rsp_tdata = {7'd0,
                       rsp_item.turbo_b_rate_out,
                       rsp_item.turbo_a_rate_out,
                       rsp_item.horizontal_stretch,
                       rsp_item.vertical_stretch,
                       rsp_item.brightness_out,
                       rsp_item.volume_out,
                       rsp_item.menu_shown,
                       rsp_item.button_word};

   gptm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gptm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (rsp_item)
   );

endmodule

@@ tb/gptm_checker.sv @@
// checker for the gamepad input block: tracks settings and state, predicts and compares reports
`timescale 1ns / 1ps
module gptm_checker
   import gptm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatches,
   output int          waiting_reports
);

   typedef struct packed {
      logic       engaged;
      logic       fire_bit;
      logic [7:0] phase;
   } autofire_type;

   // settings
   logic [10:0] threshold;
   logic [4:0]  rate_count;
   logic [7:0]  phase_wrap;
   logic [5:0]  toggle_hold;
   logic [5:0]  repeat_hold;

   // pad state
   logic [5:0] hold_off;
   logic       menu_open;
   logic [2:0] volume;
   logic [2:0] brightness;
   logic       stretch_v;
   logic       stretch_h;
   logic [3:0] rate_a;
   logic [3:0] rate_b;
   logic [7:0] phase_a;
   logic [7:0] phase_b;

   rsp_item_type awaited_reports[$];

   initial begin
      mismatches = 0;
      waiting_reports = 0;
   end

   function automatic logic [3:0] advance_rate(logic [3:0] rate);
      int span;
      span = (rate_count == 0) ? 1 : (rate_count > RateCountMax) ? RateCountMax : rate_count;
      return 4'((rate + 1) % span);
   endfunction

   function automatic autofire_type autofire_step(logic [3:0] rate, logic held,
                                                  logic [7:0] phase);
      autofire_type step;
      int wrap_span;
      wrap_span = (phase_wrap == 0) ? 256 : phase_wrap;
      step.engaged = (rate != 0) && held;
      step.fire_bit = 1'b1;
      step.phase = 8'd0;
      if (step.engaged) begin
         // fire is pressed only on the first poll of each 2*rate window
         step.fire_bit = ((phase % (rate * 2)) != 0);
         step.phase = 8'((phase + 1) % wrap_span);
      end
      return step;
   endfunction

   function automatic rsp_item_type poll_gamepad(req_item_type poll);
      rsp_item_type report;
      logic [15:0] word;
      autofire_type step_a;
      autofire_type step_b;
      int sx;
      int sy;
      int limit;
      sx = $signed(poll.stick_x);
      sy = $signed(poll.stick_y);
      limit = threshold;
      word = WordIdle;
      if (hold_off != 0) hold_off = hold_off - 6'd1;
      if (sx > limit) word[BitRight] = 1'b0;
      if (sx < -limit) word[BitLeft] = 1'b0;
      if (sy < -limit) word[BitUp] = 1'b0;
      if (sy > limit) word[BitDown] = 1'b0;
      if (poll.fire_a) word[BitFireA] = 1'b0;
      if (poll.fire_b) word[BitFireB] = 1'b0;
      if (poll.touched) begin
         if (poll.touch_x > SelectLo && poll.touch_x < SelectHi) word[BitSelect] = 1'b0;
         else if (poll.touch_x != 0 && poll.touch_x < StartHi) word[BitStart] = 1'b0;
      end
      if (poll.turbo_a_held) word[BitTurboA] = 1'b0;
      if (poll.turbo_b_held) word[BitTurboB] = 1'b0;
      if (poll.menu_held) word[BitMenu] = 1'b0;
      if (poll.power_held) word[BitPower] = 1'b0;

      if (!word[BitMenu] && hold_off == 0) begin
         menu_open = !menu_open;
         hold_off = toggle_hold;
      end

      if (menu_open) begin
         if (hold_off == 0) begin
            if (!word[BitUp] && volume < LevelMax) volume = volume + 3'd1;
            if (!word[BitDown] && volume > 0) volume = volume - 3'd1;
            if (!word[BitRight] && brightness < LevelMax) brightness = brightness + 3'd1;
            if (!word[BitLeft] && brightness > 0) brightness = brightness - 3'd1;
            if (!word[BitFireA]) stretch_v = !stretch_v;
            if (!word[BitFireB]) stretch_h = !stretch_h;
            if (!word[BitTurboA]) rate_a = advance_rate(rate_a);
            if (!word[BitTurboB]) rate_b = advance_rate(rate_b);
            if (word != WordIdle) hold_off = repeat_hold;
         end
      end else begin
         step_a = autofire_step(rate_a, !word[BitTurboA], phase_a);
         phase_a = step_a.phase;
         if (step_a.engaged) word[BitFireA] = step_a.fire_bit;
         step_b = autofire_step(rate_b, !word[BitTurboB], phase_b);
         phase_b = step_b.phase;
         if (step_b.engaged) word[BitFireB] = step_b.fire_bit;
      end

      report.button_word = word;
      report.menu_shown = menu_open;
      report.volume_out = volume;
      report.brightness_out = brightness;
      report.vertical_stretch = stretch_v;
      report.horizontal_stretch = stretch_h;
      report.turbo_a_rate_out = rate_a;
      report.turbo_b_rate_out = rate_b;
      return report;
   endfunction

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         if (mismatches < 10)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      req_item_type poll;
      if (reset) begin
         threshold = StickThresholdRst;
         rate_count = TurboRateCountRst;
         phase_wrap = TurboPhaseWrapRst;
         toggle_hold = MenuToggleHoldRst;
         repeat_hold = MenuRepeatHoldRst;
         hold_off = '0;
         menu_open = 1'b0;
         volume = VolumeRst;
         brightness = BrightnessRst;
         stretch_v = 1'b0;
         stretch_h = 1'b0;
         rate_a = TurboRateRst;
         rate_b = TurboRateRst;
         phase_a = '0;
         phase_b = '0;
         awaited_reports.delete();
      end else begin
         // reports are checked before this edge's poll is queued
         if (rsp_tvalid && rsp_tready) begin
            got.button_word = rsp_tdata[15:0];
            got.menu_shown = rsp_tdata[16];
            got.volume_out = rsp_tdata[19:17];
            got.brightness_out = rsp_tdata[22:20];
            got.vertical_stretch = rsp_tdata[23];
            got.horizontal_stretch = rsp_tdata[24];
            got.turbo_a_rate_out = rsp_tdata[28:25];
            got.turbo_b_rate_out = rsp_tdata[32:29];
            if (awaited_reports.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected report beat 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("button_word", want.button_word, got.button_word);
               check_field("menu_shown", want.menu_shown, got.menu_shown);
               check_field("volume_out", want.volume_out, got.volume_out);
               check_field("brightness_out", want.brightness_out, got.brightness_out);
               check_field("vertical_stretch", want.vertical_stretch, got.vertical_stretch);
               check_field("horizontal_stretch", want.horizontal_stretch,
                           got.horizontal_stretch);
               check_field("turbo_a_rate_out", want.turbo_a_rate_out, got.turbo_a_rate_out);
               check_field("turbo_b_rate_out", want.turbo_b_rate_out, got.turbo_b_rate_out);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_STICK_THRESHOLD:  threshold = csr_pwdata[10:0];
               REG_TURBO_RATE_COUNT: rate_count = csr_pwdata[4:0];
               REG_TURBO_PHASE_WRAP: phase_wrap = csr_pwdata[7:0];
               REG_MENU_TOGGLE_HOLD: toggle_hold = csr_pwdata[5:0];
               REG_MENU_REPEAT_HOLD: repeat_hold = csr_pwdata[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            poll.stick_x = req_tdata[11:0];
            poll.stick_y = req_tdata[23:12];
            poll.fire_a = req_tdata[24];
            poll.fire_b = req_tdata[25];
            poll.touched = req_tdata[26];
            poll.touch_x = req_tdata[36:27];
            poll.turbo_a_held = req_tdata[37];
            poll.turbo_b_held = req_tdata[38];
            poll.menu_held = req_tdata[39];
            poll.power_held = req_tdata[40];
            awaited_reports.push_back(poll_gamepad(poll));
         end
      end
      waiting_reports = awaited_reports.size();
   end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the gamepad input block: clock, reset, settings, poll and stall stimulus
`timescale 1ns / 1ps
module tb_top
   import gptm_pkg::*;
();

   localparam int LongHold = 400;
   localparam int WatchdogLimit = 4000;
   localparam int SettleCycles = 48;
   localparam int PollsPerSetting = 225;

   // button masks for directed polls
   localparam logic [5:0] KeyFireA  = 6'b000001;
   localparam logic [5:0] KeyFireB  = 6'b000010;
   localparam logic [5:0] KeyTurboA = 6'b000100;
   localparam logic [5:0] KeyTurboB = 6'b001000;
   localparam logic [5:0] KeyMenu   = 6'b010000;
   localparam logic [5:0] KeyPower  = 6'b100000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [47:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatches;
   int waiting_reports;
   int quiet_cycles = 0;
   int report_beats = 0;
   int stick_limit = 500;
   logic turbo_a_down = 1'b0;
   logic turbo_b_down = 1'b0;
   req_item_type poll_q[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   gamepad_turbo_menu_input_top uut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   gptm_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .mismatches(mismatches),
      .waiting_reports(waiting_reports)
   );

   function automatic logic [47:0] pack_poll(req_item_type p);
      return {7'd0, p.power_held, p.menu_held, p.turbo_b_held, p.turbo_a_held, p.touch_x,
              p.touched, p.fire_b, p.fire_a, p.stick_y, p.stick_x};
   endfunction

   function automatic req_item_type make_poll(int sx, int sy, logic [5:0] keys,
                                              logic touched, int tx);
      req_item_type p;
      p.stick_x = 12'(sx);
      p.stick_y = 12'(sy);
      p.fire_a = |(keys & KeyFireA);
      p.fire_b = |(keys & KeyFireB);
      p.touched = touched;
      p.touch_x = 10'(tx);
      p.turbo_a_held = |(keys & KeyTurboA);
      p.turbo_b_held = |(keys & KeyTurboB);
      p.menu_held = |(keys & KeyMenu);
      p.power_held = |(keys & KeyPower);
      return p;
   endfunction

   // axis values cluster around the current threshold and the extremes
   function automatic logic [11:0] pick_axis();
      int near;
      near = (stick_limit < 2047) ? stick_limit + 1 : 2047;
      case ($urandom_range(0, 7))
         0: return 12'd0;
         1: return 12'(stick_limit);
         2: return 12'(-stick_limit);
         3: return 12'(near);
         4: return 12'(-near);
         5: return 12'h7FF;
         6: return 12'h800;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [9:0] pick_touch();
      case ($urandom_range(0, 10))
         0: return 10'd0;
         1: return 10'd1;
         2: return 10'd79;
         3: return 10'd80;
         4: return 10'd320;
         5: return 10'd321;
         6: return 10'd479;
         7: return 10'd480;
         8: return 10'd1023;
         default: return 10'($urandom);
      endcase
   endfunction

   function automatic req_item_type random_poll();
      req_item_type p;
      if ($urandom_range(0, 9) == 0) begin
         {p.stick_x, p.stick_y} = 24'($urandom);
         {p.fire_a, p.fire_b, p.touched, p.touch_x, p.turbo_a_held, p.turbo_b_held,
          p.menu_held, p.power_held} = 17'($urandom);
      end else begin
         // turbo buttons stay down for long runs so the phase counters wrap
         if ($urandom_range(0, 19) == 0) turbo_a_down = !turbo_a_down;
         if ($urandom_range(0, 19) == 0) turbo_b_down = !turbo_b_down;
         p.stick_x = pick_axis();
         p.stick_y = pick_axis();
         p.fire_a = ($urandom_range(0, 3) == 0);
         p.fire_b = ($urandom_range(0, 3) == 0);
         p.touched = ($urandom_range(0, 2) == 0);
         p.touch_x = pick_touch();
         p.turbo_a_held = turbo_a_down;
         p.turbo_b_held = turbo_b_down;
         p.menu_held = ($urandom_range(0, 24) == 0);
         p.power_held = ($urandom_range(0, 19) == 0);
      end
      return p;
   endfunction

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_setting(int thr, int cnt, int wrap, int tog, int rep);
      csr_write(REG_STICK_THRESHOLD, thr);
      csr_write(REG_TURBO_RATE_COUNT, cnt);
      csr_write(REG_TURBO_PHASE_WRAP, wrap);
      csr_write(REG_MENU_TOGGLE_HOLD, tog);
      csr_write(REG_MENU_REPEAT_HOLD, rep);
      stick_limit = thr;
   endtask

   // sends the queued polls in bursts with random gaps
   task automatic drive_polls();
      int burst_left;
      burst_left = $urandom_range(1, 64);
      while (poll_q.size() > 0) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            burst_left = $urandom_range(1, 64);
         end
         req_tvalid <= 1'b1;
         req_tdata <= pack_poll(poll_q.pop_front());
         do @(posedge clock); while (!req_tready);
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (waiting_reports != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) report_beats <= report_beats + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // report sink: stall pattern changes after each randomly sized span, one long hold-off
   initial begin : sink
      int stall_mode;
      int span;
      int tick;
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         stall_mode = $urandom_range(0, 3);
         span = $urandom_range(16, 160);
         for (tick = 0; tick < span; tick++) begin
            @(posedge clock);
            if (!long_hold_done && report_beats >= 300 && req_tvalid) begin
               rsp_tready <= 1'b0;
               repeat (LongHold) @(posedge clock);
               long_hold_done = 1'b1;
            end
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 4 == 3);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int setting;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero hold-offs so menu actions show up right away
      csr_write(REG_MENU_TOGGLE_HOLD, 0);
      csr_write(REG_MENU_REPEAT_HOLD, 0);
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(2047, -2048, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(-2048, 2047, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(501, -501, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(-501, 501, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(500, -500, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 321));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 479));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 320));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 480));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 1));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 79));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 0));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b1, 1023));
      poll_q.push_back(make_poll(0, 0, 6'd0, 1'b0, 400));
      poll_q.push_back(make_poll(0, 0, KeyFireA | KeyFireB | KeyPower, 1'b0, 0));
      repeat (4)
         poll_q.push_back(make_poll(0, 0, KeyTurboA | KeyTurboB | KeyFireA | KeyFireB, 1'b0, 0));
      poll_q.push_back(make_poll(0, 0, KeyMenu, 1'b0, 0));
      poll_q.push_back(make_poll(2047, -2048, 6'd0, 1'b0, 0));
      poll_q.push_back(make_poll(-2048, 2047, KeyFireA | KeyFireB, 1'b0, 0));
      poll_q.push_back(make_poll(0, 0, KeyTurboA | KeyTurboB, 1'b0, 0));
      poll_q.push_back(make_poll(0, 0, KeyMenu, 1'b0, 0));
      drive_polls();
      drain();

      for (setting = 0; setting < 6; setting++) begin
         case (setting)
            0: apply_setting(0, 1, 1, 0, 0);
            1: apply_setting(2047, 16, 255, 63, 63);
            2: apply_setting(500, 6, 210, 20, 15);
            // rate count and phase wrap of zero
            3: apply_setting(37, 0, 0, 2, 1);
            // rate count above range, and a wrap below the phase left from before
            4: apply_setting(1500, 31, 5, 1, 3);
            default: apply_setting($urandom_range(0, 2047), $urandom_range(1, 16),
                                   $urandom_range(1, 255), $urandom_range(0, 63),
                                   $urandom_range(0, 63));
         endcase
         repeat (PollsPerSetting) poll_q.push_back(random_poll());
         drive_polls();
         drain();
      end

      if (mismatches == 0 && waiting_reports == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
